>>> rtl/fsrx_pkg.sv
`default_nettype none

package fsrx_pkg;

    // largest frame the receiver accepts, start byte not counted
    localparam int MAX_FRAME = 512;
    // byte position counter: the highest position reached is MAX_FRAME - 1
    localparam int POS_W     = $clog2(MAX_FRAME);
    localparam int LEN_W     = 16;
    // width for position and length sums
    localparam int CMP_W     = LEN_W + 1;
    localparam int CRC_W     = 16;
    localparam int BYTE_W    = 8;
    localparam int POSOUT_W  = 9;
    localparam int ERR_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int M_DATA_W  = 24;

    localparam logic [BYTE_W-1:0] START_RESET = 8'h02;
    localparam logic [BYTE_W-1:0] END_RESET   = 8'h03;
    localparam logic [CRC_W-1:0]  POLY_RESET  = 16'h8408;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE     = 3'd0,
        ERR_END_BYTE = 3'd1,
        ERR_CRC      = 3'd2,
        ERR_ZERO_LEN = 3'd3,
        ERR_TOO_LONG = 3'd4
    } err_code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_BYTE = 2'd0,
        CFG_END_BYTE   = 2'd1,
        CFG_CRC_POLY   = 2'd2
    } cfg_reg_t;

    // crc register and polynomial handed to the byte update
    typedef struct packed {
        logic [CRC_W-1:0] crc;
        logic [CRC_W-1:0] poly;
    } crc_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/framed_serial_receiver_crc16.sv
`default_nettype none

// channel  | dir | handshake                     | content
// ---------+-----+-------------------------------+-------------------------------
// s_*      | in  | s_tvalid / s_tready           | received byte
// m_*      | out | m_tvalid / m_tready           | status word per byte, tlast = frame end
// cfg_*    | in  | cfg_valid / cfg_ready         | register index and value
//
// one word in, one status word out; a new byte is taken every cycle while m_tready does not stall the output
// each byte passes two registers: the input register, then the framing/crc step into the result register
// the byte-wide crc update and the position compares sit between those two registers
// stalls on m_tready back up through the input register; no word is dropped
// asynchronous active-low reset returns to hunting with default start, end and polynomial

module framed_serial_receiver_crc16 (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // slave side
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [fsrx_pkg::BYTE_W-1:0]         s_tdata,   // [7:0] rx_byte
    // master side
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [0] in_frame, [9:1] position, [17:10] data, [18] checked_byte,
    // [21:19] error_code, [23:22] zero
    output logic [fsrx_pkg::M_DATA_W-1:0]            m_tdata,
    output logic                                     m_tlast,   // frame_done
    // configuration writes
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [fsrx_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  wire logic [fsrx_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import fsrx_pkg::*;

    // configuration
    logic [BYTE_W-1:0] start_byte_reg;
    logic [BYTE_W-1:0] end_byte_reg;
    logic [CRC_W-1:0]  crc_poly_reg;

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // result register
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic                out_last_reg;

    // frame tracking state
    logic              synced_reg,      synced_next;
    logic [POS_W-1:0]  byte_pos_reg,    byte_pos_next;
    logic [BYTE_W-1:0] length_high_reg, length_high_next;
    logic [LEN_W-1:0]  payload_len_reg, payload_len_next;
    logic [CRC_W-1:0]  crc_acc_reg,     crc_acc_next;
    logic              end_ok_reg,      end_ok_next;
    logic [BYTE_W-1:0] crc_high_rx_reg, crc_high_rx_next;

    // per-byte status
    logic                in_frame;
    logic [POSOUT_W-1:0] position;
    logic                checked;
    logic                done;
    err_code_t           err;
    logic [LEN_W-1:0]    len_new;
    logic [CMP_W-1:0]    pos_w;
    logic [CMP_W-1:0]    len_w;
    logic [CRC_W-1:0]    crc_upd;
    crc_ctrl_t           crc_ctrl;
    logic                advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    assign crc_ctrl.crc  = crc_acc_reg;
    assign crc_ctrl.poly = crc_poly_reg;

    fsrx_crc_byte u_crc (
        .ctrl    (crc_ctrl),
        .data    (in_byte_reg),
        .crc_out (crc_upd)
    );

    // register writes; the user must do them only while the block is idle, the block itself does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= START_RESET;
            end_byte_reg   <= END_RESET;
            crc_poly_reg   <= POLY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_addr)
                CFG_START_BYTE: start_byte_reg <= cfg_data[BYTE_W-1:0];
                CFG_END_BYTE:   end_byte_reg   <= cfg_data[BYTE_W-1:0];
                CFG_CRC_POLY:   crc_poly_reg   <= cfg_data[CRC_W-1:0];
                default:        ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    // framing decisions, all from the state left by the previous byte
    always_comb
    begin
        synced_next      = synced_reg;
        byte_pos_next    = byte_pos_reg;
        length_high_next = length_high_reg;
        payload_len_next = payload_len_reg;
        crc_acc_next     = crc_acc_reg;
        end_ok_next      = end_ok_reg;
        crc_high_rx_next = crc_high_rx_reg;

        in_frame = 1'b0;
        position = '0;
        checked  = 1'b0;
        done     = 1'b0;
        err      = ERR_NONE;
        len_new  = {length_high_reg, in_byte_reg};
        pos_w    = CMP_W'(byte_pos_reg);
        len_w    = CMP_W'(payload_len_reg);

        if (!synced_reg)
        begin
            // hunting: only the start byte does anything
            if (in_byte_reg == start_byte_reg)
            begin
                synced_next      = 1'b1;
                byte_pos_next    = '0;
                length_high_next = '0;
                payload_len_next = '0;
                crc_acc_next     = '0;
                end_ok_next      = 1'b0;
                crc_high_rx_next = '0;
            end
        end
        else
        begin
            in_frame = 1'b1;
            position = POSOUT_W'(byte_pos_reg);

            // header and payload are covered by the crc
            if (pos_w <= CMP_W'(3) || pos_w <= len_w + CMP_W'(3))
            begin
                checked      = 1'b1;
                crc_acc_next = crc_upd;
            end

            if (byte_pos_reg == POS_W'(2))
            begin
                length_high_next = in_byte_reg;
            end
            else if (byte_pos_reg == POS_W'(3))
            begin
                payload_len_next = len_new;
                if (len_new == '0)
                begin
                    done = 1'b1;
                    err  = ERR_ZERO_LEN;
                end
                else if (CMP_W'(len_new) + CMP_W'(7) > CMP_W'(MAX_FRAME))
                begin
                    done = 1'b1;
                    err  = ERR_TOO_LONG;
                end
            end
            else if (byte_pos_reg > POS_W'(3))
            begin
                if (pos_w == len_w + CMP_W'(4))
                begin
                    end_ok_next = (in_byte_reg == end_byte_reg);
                end
                else if (pos_w == len_w + CMP_W'(5))
                begin
                    crc_high_rx_next = in_byte_reg;
                end
                else if (pos_w == len_w + CMP_W'(6))
                begin
                    // a bad end byte outranks a crc mismatch
                    done = 1'b1;
                    if (!end_ok_reg)
                    begin
                        err = ERR_END_BYTE;
                    end
                    else if ({crc_high_rx_reg, in_byte_reg} != crc_acc_reg)
                    begin
                        err = ERR_CRC;
                    end
                end
            end

            if (done)
            begin
                // any frame end, good or bad, goes back to hunting
                synced_next      = 1'b0;
                byte_pos_next    = '0;
                length_high_next = '0;
                payload_len_next = '0;
                crc_acc_next     = '0;
                end_ok_next      = 1'b0;
                crc_high_rx_next = '0;
            end
            else
            begin
                byte_pos_next = byte_pos_reg + POS_W'(1);
            end
        end
    end

    // frame state moves once per byte handed to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            synced_reg      <= 1'b0;
            byte_pos_reg    <= '0;
            length_high_reg <= '0;
            payload_len_reg <= '0;
            crc_acc_reg     <= '0;
            end_ok_reg      <= 1'b0;
            crc_high_rx_reg <= '0;
        end
        else if (advance)
        begin
            synced_reg      <= synced_next;
            byte_pos_reg    <= byte_pos_next;
            length_high_reg <= length_high_next;
            payload_len_reg <= payload_len_next;
            crc_acc_reg     <= crc_acc_next;
            end_ok_reg      <= end_ok_next;
            crc_high_rx_reg <= crc_high_rx_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {2'b00, err, checked, in_byte_reg, position, in_frame};
            out_last_reg <= done;
        end
    end

endmodule

`default_nettype wire

>>> rtl/fsrx_crc_byte.sv
`default_nettype none

module fsrx_crc_byte (
    input  wire fsrx_pkg::crc_ctrl_t          ctrl,
    input  wire logic [fsrx_pkg::BYTE_W-1:0]  data,
    output logic [fsrx_pkg::CRC_W-1:0]        crc_out
);
    import fsrx_pkg::*;

    logic [CRC_W-1:0] c;

    // reflected update, lsb first, eight shifts
    always_comb
    begin
        c = ctrl.crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ ctrl.poly;
            end
            else
            begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

`default_nettype wire

>>> dv/fsrx_tb_pkg.sv
`timescale 1ns / 1ps

package fsrx_tb_pkg;

    import fsrx_pkg::*;

    // one status word as the receiver should report it
    typedef struct {
        logic                in_frame;
        logic [POSOUT_W-1:0] position;
        logic [BYTE_W-1:0]   data;
        logic                checked;
        logic                done;
        err_code_t           err;
    } status_t;

    class frame_status_tracker;

        // register copies
        logic [BYTE_W-1:0] start_code;
        logic [BYTE_W-1:0] end_code;
        logic [CRC_W-1:0]  poly;

        // framing state
        bit                synced;
        int                byte_pos;
        int                length_high;
        int                payload_len;
        logic [CRC_W-1:0]  crc_acc;
        bit                end_ok;
        logic [BYTE_W-1:0] crc_high_rx;

        status_t           pending_status[$];
        int unsigned       mismatches;

        function new();
            start_code  = START_RESET;
            end_code    = END_RESET;
            poly        = POLY_RESET;
            mismatches  = 0;
            drop_sync();
        endfunction

        function void drop_sync();
            synced      = 1'b0;
            byte_pos    = 0;
            length_high = 0;
            payload_len = 0;
            crc_acc     = '0;
            end_ok      = 1'b0;
            crc_high_rx = '0;
        endfunction

        function void set_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
            case (r)
                CFG_START_BYTE: start_code = v[BYTE_W-1:0];
                CFG_END_BYTE:   end_code   = v[BYTE_W-1:0];
                CFG_CRC_POLY:   poly       = v[CRC_W-1:0];
                default:        ;
            endcase
        endfunction

        // reflected crc, lsb first
        function logic [CRC_W-1:0] crc_step(logic [CRC_W-1:0] crc, logic [BYTE_W-1:0] b);
            logic [CRC_W-1:0] c;
            c = crc ^ {8'h00, b};
            for (int k = 0; k < 8; k++)
            begin
                if (c[0])
                    c = (c >> 1) ^ poly;
                else
                    c = c >> 1;
            end
            return c;
        endfunction

        function int pending();
            return pending_status.size();
        endfunction

        function void note_rx_byte(logic [BYTE_W-1:0] b);
            status_t s;
            int      pos;
            s.in_frame = 1'b0;
            s.position = '0;
            s.data     = b;
            s.checked  = 1'b0;
            s.done     = 1'b0;
            s.err      = ERR_NONE;
            if (!synced)
            begin
                if (b == start_code)
                begin
                    drop_sync();
                    synced = 1'b1;
                end
            end
            else
            begin
                pos        = byte_pos;
                s.in_frame = 1'b1;
                s.position = pos[POSOUT_W-1:0];
                if (pos <= 3 || pos <= payload_len + 3)
                begin
                    s.checked = 1'b1;
                    crc_acc   = crc_step(crc_acc, b);
                end
                if (pos == 2)
                    length_high = int'(b);
                else if (pos == 3)
                begin
                    payload_len = (length_high << 8) | int'(b);
                    if (payload_len == 0)
                    begin
                        s.done = 1'b1;
                        s.err  = ERR_ZERO_LEN;
                    end
                    else if (payload_len + 7 > MAX_FRAME)
                    begin
                        s.done = 1'b1;
                        s.err  = ERR_TOO_LONG;
                    end
                end
                else if (pos > 3)
                begin
                    if (pos == payload_len + 4)
                        end_ok = (b == end_code);
                    else if (pos == payload_len + 5)
                        crc_high_rx = b;
                    else if (pos == payload_len + 6)
                    begin
                        s.done = 1'b1;
                        if (!end_ok)
                            s.err = ERR_END_BYTE;
                        else if ({crc_high_rx, b} != crc_acc)
                            s.err = ERR_CRC;
                    end
                end
                if (s.done)
                    drop_sync();
                else
                    byte_pos = pos + 1;
            end
            pending_status.push_back(s);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_status_word(logic [M_DATA_W-1:0] w, logic last);
            status_t s;
            if (pending_status.size() == 0)
            begin
                $error("status word 0x%0h with no byte pending", w);
                mismatches++;
                return;
            end
            s = pending_status.pop_front();
            compare_field("in_frame",     32'(s.in_frame), 32'(w[0]));
            compare_field("position",     32'(s.position), 32'(w[9:1]));
            compare_field("data",         32'(s.data),     32'(w[17:10]));
            compare_field("checked_byte", 32'(s.checked),  32'(w[18]));
            compare_field("error_code",   32'(s.err),      32'(w[21:19]));
            compare_field("pad",          32'(0),          32'(w[23:22]));
            compare_field("frame_done",   32'(s.done),     32'(last));
        endfunction

    endclass

endpackage

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import fsrx_pkg::*;
    import fsrx_tb_pkg::*;

    localparam int CLK_HALF        = 2;
    localparam int RESET_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int PHASE_FRAMED    = 80;
    localparam int HOLD_OFF_AT     = 60;
    localparam int HOLD_OFF_CYCLES = 300;
    // covers the input and result registers plus margin
    localparam int DRAIN_CYCLES    = 8;

    // what to spoil in the frame trailer
    typedef enum int {
        FAULT_NONE,
        FAULT_END,
        FAULT_CRC,
        FAULT_BOTH
    } frame_fault_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_addr  = CFG_START_BYTE;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    frame_status_tracker tracker = new();

    bit tx_rush      = 1'b0;
    int framed_bytes = 0;
    int cycle_count  = 0;

    framed_serial_receiver_crc16 dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // offer one byte, optionally after an idle gap; tvalid stays high on return,
    // so whoever stops sending must drop it in the same step
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = tx_rush ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        tracker.note_rx_byte(b);
    endtask

    // start byte, two free header bytes, big-endian length, payload, end byte, crc
    task automatic send_frame(input int len, input frame_fault_t fault);
        logic [CRC_W-1:0]  crc;
        logic [BYTE_W-1:0] b;
        logic [LEN_W-1:0]  len16;
        len16   = len[LEN_W-1:0];
        crc     = '0;
        tx_rush = ($urandom_range(0, 3) == 0);
        send_byte(tracker.start_code);
        for (int i = 0; i < 4 + len; i++)
        begin
            if (i == 2)
                b = len16[15:8];
            else if (i == 3)
                b = len16[7:0];
            else
                b = 8'($urandom_range(0, 255));
            crc = tracker.crc_step(crc, b);
            send_byte(b);
            framed_bytes++;
            // zero or oversize length ends the frame at the length byte
            if (i == 3 && (len == 0 || len + 7 > MAX_FRAME))
                return;
        end
        b = tracker.end_code;
        if (fault == FAULT_END || fault == FAULT_BOTH)
            b = b ^ 8'($urandom_range(1, 255));
        send_byte(b);
        if (fault == FAULT_CRC || fault == FAULT_BOTH)
            crc = crc ^ 16'($urandom_range(1, 65535));
        send_byte(crc[15:8]);
        send_byte(crc[7:0]);
        framed_bytes += 3;
    endtask

    // line noise while hunting; may now and then hit the start byte
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    function automatic int frame_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(13, 80);
        return $urandom_range(1, 12);
    endfunction

    // mostly well-formed frames, the rest broken trailers, bad lengths and noise
    task automatic random_frames(input int quota);
        int target;
        int pick;
        target = framed_bytes + quota;
        while (framed_bytes < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_frame(frame_len(), FAULT_NONE);
            else if (pick < 65)
                send_frame(frame_len(), FAULT_END);
            else if (pick < 75)
                send_frame(frame_len(), FAULT_CRC);
            else if (pick < 80)
                send_frame(frame_len(), FAULT_BOTH);
            else if (pick < 85)
                send_frame(0, FAULT_NONE);
            else if (pick < 90)
                send_frame($urandom_range(MAX_FRAME - 6, 65535), FAULT_NONE);
            else
                send_noise();
        end
    endtask

    // stop offering and let every pending status word come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_addr  <= r;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.set_reg(r, v);
    endtask

    task automatic load_config(input logic [BYTE_W-1:0] start_code,
                               input logic [BYTE_W-1:0] end_code,
                               input logic [CRC_W-1:0] poly);
        put_reg(CFG_START_BYTE, {8'h00, start_code});
        put_reg(CFG_END_BYTE, {8'h00, end_code});
        put_reg(CFG_CRC_POLY, poly);
        cfg_valid <= 1'b0;
    endtask

    // status word sink: random stalls, bursts of full rate, one long hold-off
    initial
    begin
        int stall;
        int seen;
        bit rx_rush;
        bit held;
        seen    = 0;
        rx_rush = 1'b0;
        held    = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (seen % 32 == 0)
                rx_rush = ($urandom_range(0, 2) == 0);
            if (!held && seen == HOLD_OFF_AT)
            begin
                // sender keeps going, so the pipeline fills and s_tready drops
                held  = 1'b1;
                stall = HOLD_OFF_CYCLES;
            end
            else
                stall = rx_rush ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            tracker.check_status_word(m_tdata, m_tlast);
            seen++;
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset settings: noise at both byte extremes, zero length,
        // largest length field, good frame, bad end byte masking a bad crc
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(0, FAULT_NONE);
        send_frame(65535, FAULT_NONE);
        send_frame(1, FAULT_NONE);
        send_frame(1, FAULT_BOTH);

        random_frames(PHASE_FRAMED);
        wait_drained();

        // all-zero start and poly, all-ones end byte; sender pauses midway
        load_config(8'h00, 8'hFF, 16'h0000);
        random_frames(PHASE_FRAMED / 2);
        wait_drained();
        random_frames(PHASE_FRAMED / 2);
        wait_drained();

        // the other extremes, plus the smallest oversize length
        load_config(8'hFF, 8'h00, 16'hFFFF);
        send_frame(MAX_FRAME - 6, FAULT_NONE);
        random_frames(PHASE_FRAMED);
        wait_drained();

        load_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    16'($urandom_range(0, 65535)));
        random_frames(PHASE_FRAMED);
        wait_drained();

        if (tracker.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> files.f
rtl/fsrx_pkg.sv
rtl/fsrx_crc_byte.sv
rtl/framed_serial_receiver_crc16.sv
dv/fsrx_tb_pkg.sv
dv/tb_top.sv
